// File: rtl/apq_pkg.sv
package apq_pkg;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Default queue depth
    localparam int SLOT_COUNT_DEF = 8;

    // Command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Control from the sequencer to the max-scan unit
    typedef struct packed {
        logic start;   // clear the running maximum
        logic take;    // offer the current read data as a candidate
    } t_scan_ctl;

endpackage

// File: rtl/apq_ram.sv
module apq_ram #(
    parameter int DEPTH = apq_pkg::SLOT_COUNT_DEF,
    parameter int WIDTH = apq_pkg::VALUE_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/apq_scan.sv
module apq_scan #(
    parameter int SLOT_COUNT = apq_pkg::SLOT_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  apq_pkg::t_scan_ctl                 i_ctl,
    input  logic signed [apq_pkg::VALUE_W-1:0] i_data,
    input  logic [$clog2(SLOT_COUNT)-1:0]      i_index,
    output logic signed [apq_pkg::VALUE_W-1:0] o_best,
    output logic [$clog2(SLOT_COUNT)-1:0]      o_pos,
    output logic                               o_found
);
    import apq_pkg::*;

    logic better;

    // Strict compare keeps the lowest slot on ties
    assign better = !o_found || (i_data > o_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found <= 1'b0;
        end else if (i_ctl.start) begin
            o_found <= 1'b0;
        end else if (i_ctl.take && better) begin
            o_found <= 1'b1;
            o_best  <= i_data;
            o_pos   <= i_index;
        end
    end

endmodule

// File: rtl/array_priority_queue_delete_max.sv
// Channel  | Direction | Valid        | Stall        | Payload
// ---------+-----------+--------------+--------------+-------------------------------------------
// command  | in        | i_in_valid   | o_in_stall   | i_cmd, i_value_in
// result   | out       | o_out_valid  | i_out_stall  | o_status, o_removed_value, o_is_empty,
//          |           |              |              | o_is_full
//
// An add or a refused transaction goes from acceptance to S_DONE, which loads the result
// register once it is free. A delete on a non-empty queue passes through S_SCAN, which
// reads one slot per cycle from the value memory, then S_DRAIN for the registered read
// data and S_FIN to commit, before S_DONE.
// Reset (synchronous, active low) clears the deleted marks and both counters; no memory sweep.
// The result register holds one finished transaction, so a new command is taken while it
// waits; a stalled result only holds the block once the next result is ready.
module array_priority_queue_delete_max #(
    parameter int SLOT_COUNT = apq_pkg::SLOT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic signed [apq_pkg::VALUE_W-1:0]  i_value_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [apq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [apq_pkg::VALUE_W-1:0]  o_removed_value,
    output logic                                o_is_empty,
    output logic                                o_is_full
);
    import apq_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_used;      // slots used since the queue was last emptied
    logic [CNT_W-1:0]      r_live;      // undeleted entries
    logic [SLOT_COUNT-1:0] r_deleted;
    logic [IDX_W-1:0]      r_idx;       // scan read address
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;    // slot of the data now on the memory output

    // Pending result, waiting for the output register
    logic [STATUS_W-1:0]      r_res_status;
    logic signed [VALUE_W-1:0] r_res_removed;
    logic                     r_res_empty;
    logic                     r_res_full;

    logic                      accept;
    logic                      add_ok;
    logic                      last_issue;
    logic                      out_free;
    logic [CNT_W-1:0]          n_live;
    logic [CNT_W-1:0]          n_used;
    logic signed [VALUE_W-1:0] rdata;
    logic signed [VALUE_W-1:0] best;
    logic [IDX_W-1:0]          best_pos;
    logic                      found;
    t_scan_ctl                 scan_ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign add_ok     = accept && (i_cmd == CMD_ADD) && (r_used != FULL_CNT);
    assign last_issue = ((CNT_W'(r_idx) + CNT_W'(1)) == r_used);
    assign out_free   = !o_out_valid || !i_out_stall;

    // Counters after the delete commits; the counter drops to zero with the last live entry
    assign n_live = r_live - CNT_W'(1);
    assign n_used = (n_live == '0) ? '0 : r_used;

    assign scan_ctl.start = accept;
    assign scan_ctl.take  = r_rd_vld && !r_deleted[r_rd_idx];

    apq_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (add_ok),
        .i_waddr (r_used[IDX_W-1:0]),
        .i_wdata (i_value_in),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    apq_scan #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_data  (rdata),
        .i_index (r_rd_idx),
        .o_best  (best),
        .o_pos   (best_pos),
        .o_found (found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_live      <= '0;
            r_deleted   <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // Track reads in flight: one per scan cycle
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_idx <= r_idx;

            // Drop the result once taken, load a new one when ready
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_removed <= '0;
                        if (i_cmd == CMD_ADD) begin
                            if (r_used == FULL_CNT) begin
                                r_res_status <= ST_FULL;
                                r_res_empty  <= (r_used == '0);
                                r_res_full   <= 1'b1;
                            end else begin
                                // Append in the next free slot and revive its mark
                                r_deleted[r_used[IDX_W-1:0]] <= 1'b0;
                                r_used       <= r_used + CNT_W'(1);
                                r_live       <= r_live + CNT_W'(1);
                                r_res_status <= ST_DONE;
                                r_res_empty  <= 1'b0;
                                r_res_full   <= ((r_used + CNT_W'(1)) == FULL_CNT);
                            end
                            r_state <= S_DONE;
                        end else if (r_used == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_res_empty  <= 1'b1;
                            r_res_full   <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one slot read per cycle up to the last used slot
                    if (last_issue) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    // Last read data enters the scan unit
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (found) begin
                        r_deleted[best_pos] <= 1'b1;
                        r_live        <= n_live;
                        r_used        <= n_used;
                        r_res_status  <= ST_DONE;
                        r_res_removed <= best;
                        r_res_empty   <= (n_used == '0);
                        r_res_full    <= (n_used == FULL_CNT);
                    end else begin
                        r_res_status  <= ST_EMPTY;
                        r_res_removed <= '0;
                        r_res_empty   <= (r_used == '0);
                        r_res_full    <= (r_used == FULL_CNT);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold the pending result until the output register frees up
                    if (out_free) begin
                        o_status        <= r_res_status;
                        o_removed_value <= r_res_removed;
                        o_is_empty      <= r_res_empty;
                        o_is_full       <= r_res_full;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Live entries never outnumber used slots
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used)
        else $error("live count exceeds used slot count");

    // The queue is empty exactly when the slot counter is zero
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) == (r_live == '0))
        else $error("slot counter and live count disagree on emptiness");

    // Slot counter stays within the array
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_CNT)
        else $error("slot counter beyond array depth");

    // A refused transaction removes nothing
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DONE) |-> (o_removed_value == '0))
        else $error("refused transaction returned a value");

endmodule
